// File: rtl/flvti_pkg.sv
package flvti_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} flvti_in_t;

	typedef struct packed {
		logic [2:0]  entry_kind;
		logic [31:0] payload_offset;
		logic [23:0] payload_size;
		logic [23:0] time_ms;
		logic        key_frame;
		logic [3:0]  codec_id;
		logic [15:0] sample_rate_hz;
		logic [1:0]  channel_count;
		logic [4:0]  sample_bits;
		logic        first_of_track;
	} flvti_out_t;

	typedef enum logic [14:0] {
		PH_FILEHDR = 15'b000000000000001,
		PH_HDRSKIP = 15'b000000000000010,
		PH_PREV    = 15'b000000000000100,
		PH_TYPE    = 15'b000000000001000,
		PH_SIZE    = 15'b000000000010000,
		PH_TIME    = 15'b000000000100000,
		PH_IGN     = 15'b000000001000000,
		PH_AFLAGS  = 15'b000000010000000,
		PH_APKT    = 15'b000000100000000,
		PH_VFLAGS  = 15'b000001000000000,
		PH_VEXTRA  = 15'b000010000000000,
		PH_VPKT    = 15'b000100000000000,
		PH_VCTS    = 15'b001000000000000,
		PH_SKIP    = 15'b010000000000000,
		PH_DEAD    = 15'b100000000000000
	} flvti_phase_t;

	localparam logic [2:0] KIND_VFRAME = 3'd0;
	localparam logic [2:0] KIND_AFRAME = 3'd1;
	localparam logic [2:0] KIND_VCONF  = 3'd2;
	localparam logic [2:0] KIND_ACONF  = 3'd3;
	localparam logic [2:0] KIND_BADSIG = 3'd4;

	localparam logic [7:0] SIG_F = 8'h46;
	localparam logic [7:0] SIG_L = 8'h4C;
	localparam logic [7:0] SIG_V = 8'h56;

	localparam logic [7:0] TAG_AUDIO = 8'd8;
	localparam logic [7:0] TAG_VIDEO = 8'd9;

	localparam logic [3:0] AFMT_NELLY8K = 4'd5;
	localparam logic [3:0] AFMT_AAC     = 4'd10;
	localparam logic [3:0] VCODEC_VP6   = 4'd4;
	localparam logic [3:0] VCODEC_VP6A  = 4'd5;
	localparam logic [3:0] VCODEC_AVC   = 4'd7;

	localparam logic [31:0] MIN_HDR_LEN = 32'd9;

	function automatic flvti_out_t flvti_entry(
		input logic [2:0]  kind,
		input logic [7:0]  flags,
		input logic [31:0] offset,
		input logic [23:0] size,
		input logic [23:0] tstamp,
		input logic        first
	);
		flvti_out_t e;
		e = '0;
		e.entry_kind     = kind;
		e.payload_offset = offset;
		e.payload_size   = size;
		e.time_ms        = tstamp;
		e.first_of_track = first;
		if (kind == KIND_VFRAME || kind == KIND_VCONF) begin
			e.key_frame = (flags[7:4] == 4'd1);
			e.codec_id  = flags[3:0];
		end else begin
			e.codec_id = flags[7:4];
			unique case (flags[3:2])
				2'd3: e.sample_rate_hz = 16'd44100;
				2'd2: e.sample_rate_hz = 16'd22050;
				2'd1: e.sample_rate_hz = 16'd11025;
				default: e.sample_rate_hz =
					(flags[7:4] == AFMT_NELLY8K) ? 16'd8000 : 16'd5512;
			endcase
			e.channel_count = flags[0] ? 2'd2 : 2'd1;
			e.sample_bits   = flags[1] ? 5'd16 : 5'd8;
		end
		return e;
	endfunction

endpackage

// File: rtl/flv_tag_indexer.sv
// FLV tag indexer: takes an FLV file as a stream of byte words, one per cycle, and
// gives one index entry for each audio or video frame and for the first AAC or H.264
// config payload of each track, plus a single bad-signature entry if the file does
// not start with "FLV". A word with start_of_file set restarts parsing at byte 0.
// Each accepted byte passes an input register and the parse logic into the result
// register, so the block sustains one byte per clock unless the result is stalled.
// Only a stalled result (out_ready low) holds the input side, after one extra byte has
// been taken into the input register.
module flv_tag_indexer
	import flvti_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  flvti_in_t  in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output flvti_out_t out_word
);

	flvti_in_t    in_s1;
	logic         in_valid_s1;
	flvti_out_t   out_s2;
	logic         out_valid_s2;
	logic         advance;

	flvti_phase_t phase_q, cur_phase, n_phase;
	logic [2:0]   fbc_q, cur_fbc, n_fbc, fbc_inc;
	logic [31:0]  pos_q, cur_pos, pos_inc;
	logic [31:0]  hlen_q, cur_hlen, n_hlen, hlen_shift;
	logic [7:0]   ttype_q, cur_ttype, n_ttype;
	logic [23:0]  ttime_q, cur_ttime, n_ttime;
	logic [23:0]  bleft_q, cur_bleft, n_bleft, bleft_dec;
	logic [7:0]   flags_q, cur_flags, n_flags;
	logic         vcs_q, cur_vcs, n_vcs;
	logic         acs_q, cur_acs, n_acs;
	logic         vfs_q, cur_vfs, n_vfs;
	logic         afs_q, cur_afs, n_afs;
	logic [7:0]   b;
	logic         emit;
	logic [2:0]   emit_kind;
	logic         emit_first;
	logic         sig_ok;

	assign advance   = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready  = !in_valid_s1 || advance;
	assign out_valid = out_valid_s2;
	assign out_word  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_word;
		end
	end

	// restart applies before the byte is parsed
	always_comb begin
		b = in_s1.data_byte;
		if (in_s1.start_of_file) begin
			cur_phase = PH_FILEHDR;
			cur_fbc   = '0;
			cur_pos   = '0;
			cur_hlen  = '0;
			cur_ttype = '0;
			cur_ttime = '0;
			cur_bleft = '0;
			cur_flags = '0;
			cur_vcs   = 1'b0;
			cur_acs   = 1'b0;
			cur_vfs   = 1'b0;
			cur_afs   = 1'b0;
		end else begin
			cur_phase = phase_q;
			cur_fbc   = fbc_q;
			cur_pos   = pos_q;
			cur_hlen  = hlen_q;
			cur_ttype = ttype_q;
			cur_ttime = ttime_q;
			cur_bleft = bleft_q;
			cur_flags = flags_q;
			cur_vcs   = vcs_q;
			cur_acs   = acs_q;
			cur_vfs   = vfs_q;
			cur_afs   = afs_q;
		end
	end

	assign fbc_inc    = cur_fbc + 3'd1;
	assign pos_inc    = cur_pos + 32'd1;
	assign bleft_dec  = cur_bleft - 24'd1;
	assign hlen_shift = {cur_hlen[23:0], b};

	always_comb begin
		unique case (cur_pos[1:0])
			2'd0: sig_ok = (b == SIG_F);
			2'd1: sig_ok = (b == SIG_L);
			default: sig_ok = (b == SIG_V);
		endcase
	end

	always_comb begin
		n_phase    = cur_phase;
		n_fbc      = cur_fbc;
		n_hlen     = cur_hlen;
		n_ttype    = cur_ttype;
		n_ttime    = cur_ttime;
		n_bleft    = cur_bleft;
		n_flags    = cur_flags;
		n_vcs      = cur_vcs;
		n_acs      = cur_acs;
		n_vfs      = cur_vfs;
		n_afs      = cur_afs;
		emit       = 1'b0;
		emit_kind  = KIND_VFRAME;
		emit_first = 1'b0;
		unique case (cur_phase)
			PH_FILEHDR: begin
				if (cur_pos <= 32'd2) begin
					if (!sig_ok) begin
						emit      = 1'b1;
						emit_kind = KIND_BADSIG;
						n_phase   = PH_DEAD;
					end
				end else if (cur_pos >= 32'd5) begin
					n_hlen = hlen_shift;
					if (cur_pos == 32'd8) begin
						n_phase = (hlen_shift > MIN_HDR_LEN) ? PH_HDRSKIP : PH_PREV;
						n_fbc   = '0;
					end
				end
			end
			PH_HDRSKIP: begin
				if (pos_inc == cur_hlen) begin
					n_phase = PH_PREV;
					n_fbc   = '0;
				end
			end
			PH_PREV: begin
				n_fbc = fbc_inc;
				if (fbc_inc >= 3'd4) begin
					n_fbc   = '0;
					n_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				n_ttype = b;
				n_bleft = '0;
				n_fbc   = '0;
				n_phase = PH_SIZE;
			end
			PH_SIZE: begin
				n_bleft = {cur_bleft[15:0], b};
				n_fbc   = fbc_inc;
				if (fbc_inc >= 3'd3) begin
					n_fbc   = '0;
					n_ttime = '0;
					n_phase = PH_TIME;
				end
			end
			PH_TIME: begin
				n_ttime = {cur_ttime[15:0], b};
				n_fbc   = fbc_inc;
				if (fbc_inc >= 3'd3) begin
					n_fbc   = '0;
					n_phase = PH_IGN;
				end
			end
			PH_IGN: begin
				n_fbc = fbc_inc;
				if (fbc_inc >= 3'd4) begin
					n_fbc = '0;
					if (cur_bleft == '0) begin
						n_phase = PH_PREV;
					end else if (cur_ttype == TAG_AUDIO) begin
						n_phase = PH_AFLAGS;
					end else if (cur_ttype == TAG_VIDEO) begin
						n_phase = PH_VFLAGS;
					end else begin
						n_phase = PH_SKIP;
					end
				end
			end
			PH_AFLAGS: begin
				n_flags = b;
				n_bleft = bleft_dec;
				if (b[7:4] == AFMT_AAC) begin
					n_phase = (bleft_dec != '0) ? PH_APKT : PH_PREV;
				end else begin
					if (bleft_dec != '0) begin
						emit       = 1'b1;
						emit_kind  = KIND_AFRAME;
						emit_first = !cur_afs;
						n_afs      = 1'b1;
					end
					n_phase = (bleft_dec != '0) ? PH_SKIP : PH_PREV;
				end
			end
			PH_APKT: begin
				n_bleft = bleft_dec;
				if (b == 8'd0) begin
					if (!cur_acs) begin
						emit      = 1'b1;
						emit_kind = KIND_ACONF;
						n_acs     = 1'b1;
					end
				end else if (bleft_dec != '0) begin
					emit       = 1'b1;
					emit_kind  = KIND_AFRAME;
					emit_first = !cur_afs;
					n_afs      = 1'b1;
				end
				n_phase = (bleft_dec != '0) ? PH_SKIP : PH_PREV;
			end
			PH_VFLAGS, PH_VEXTRA: begin
				n_bleft = bleft_dec;
				if (cur_phase == PH_VFLAGS) begin
					n_flags = b;
				end
				if (cur_phase == PH_VFLAGS &&
					(b[3:0] == VCODEC_VP6 || b[3:0] == VCODEC_VP6A)) begin
					n_phase = (bleft_dec != '0) ? PH_VEXTRA : PH_PREV;
				end else if (n_flags[3:0] == VCODEC_AVC) begin
					n_phase = (bleft_dec < 24'd4) ?
						((bleft_dec != '0) ? PH_SKIP : PH_PREV) : PH_VPKT;
				end else begin
					if (bleft_dec != '0) begin
						emit       = 1'b1;
						emit_kind  = KIND_VFRAME;
						emit_first = !cur_vfs;
						n_vfs      = 1'b1;
					end
					n_phase = (bleft_dec != '0) ? PH_SKIP : PH_PREV;
				end
			end
			PH_VPKT: begin
				n_ttype = b;
				n_bleft = bleft_dec;
				n_fbc   = '0;
				n_phase = PH_VCTS;
			end
			PH_VCTS: begin
				n_bleft = bleft_dec;
				n_fbc   = fbc_inc;
				if (fbc_inc >= 3'd3) begin
					n_fbc = '0;
					if (cur_ttype == 8'd0) begin
						if (!cur_vcs) begin
							emit      = 1'b1;
							emit_kind = KIND_VCONF;
							n_vcs     = 1'b1;
						end
					end else if (bleft_dec != '0) begin
						emit       = 1'b1;
						emit_kind  = KIND_VFRAME;
						emit_first = !cur_vfs;
						n_vfs      = 1'b1;
					end
					n_phase = (bleft_dec != '0) ? PH_SKIP : PH_PREV;
				end
			end
			PH_SKIP: begin
				n_bleft = bleft_dec;
				if (bleft_dec == '0) begin
					n_fbc   = '0;
					n_phase = PH_PREV;
				end
			end
			PH_DEAD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FILEHDR;
			fbc_q   <= '0;
			pos_q   <= '0;
			hlen_q  <= '0;
			ttype_q <= '0;
			ttime_q <= '0;
			bleft_q <= '0;
			flags_q <= '0;
			vcs_q   <= 1'b0;
			acs_q   <= 1'b0;
			vfs_q   <= 1'b0;
			afs_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= n_phase;
			fbc_q   <= n_fbc;
			pos_q   <= pos_inc;
			hlen_q  <= n_hlen;
			ttype_q <= n_ttype;
			ttime_q <= n_ttime;
			bleft_q <= n_bleft;
			flags_q <= n_flags;
			vcs_q   <= n_vcs;
			acs_q   <= n_acs;
			vfs_q   <= n_vfs;
			afs_q   <= n_afs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= emit;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (emit_kind == KIND_BADSIG) begin
				out_s2 <= '{entry_kind: KIND_BADSIG, default: '0};
			end else begin
				out_s2 <= flvti_entry(emit_kind, n_flags, pos_inc, n_bleft,
					cur_ttime, emit_first);
			end
		end
	end

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> out_valid_s2)
		else $error("emitted entry did not reach the result register");

	a_badsig_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.entry_kind == KIND_BADSIG |->
			out_s2.payload_offset == '0 && out_s2.payload_size == '0 &&
			out_s2.codec_id == '0)
		else $error("bad signature entry carries nonzero fields");

	a_config_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (out_s2.entry_kind == KIND_VCONF ||
			out_s2.entry_kind == KIND_ACONF) |-> !out_s2.first_of_track)
		else $error("config entry marked first of track");

	a_audio_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && out_s2.entry_kind == KIND_AFRAME |->
			out_s2.channel_count != '0 && out_s2.sample_bits != '0 &&
			out_s2.sample_rate_hz != '0)
		else $error("audio entry missing format fields");

	a_fbc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fbc_q < 3'd4)
		else $error("field byte count out of range");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s1 && !advance |=> in_valid_s1 && $stable(pos_q))
		else $error("input word lost or state moved during stall");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import flvti_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	flvti_in_t  in_word;
	logic       out_valid;
	logic       out_ready;
	flvti_out_t out_word;

	flv_tag_indexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	flvti_in_t   file_bytes[$];
	flvti_out_t  index_q[$];
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap_pct = 16;
	int unsigned recv_stall_pct = 69;
	logic        in_fired = 1'b0;

	// parser state mirror
	flvti_phase_t ph;
	logic [2:0]   fbc;
	logic [31:0]  fpos;
	logic [31:0]  hlen;
	logic [31:0]  hacc;
	logic [7:0]   ttype;
	logic [23:0]  ttime;
	logic [23:0]  left;
	logic [7:0]   mflags;
	logic         vconf_seen;
	logic         aconf_seen;
	logic         vframe_seen;
	logic         aframe_seen;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic clear_parser();
		ph          = PH_FILEHDR;
		fbc         = '0;
		fpos        = '0;
		hlen        = '0;
		hacc        = '0;
		ttype       = '0;
		ttime       = '0;
		left        = '0;
		mflags      = '0;
		vconf_seen  = 1'b0;
		aconf_seen  = 1'b0;
		vframe_seen = 1'b0;
		aframe_seen = 1'b0;
	endtask

	function automatic flvti_phase_t payload_phase();
		if (left != 24'd0)
			return PH_SKIP;
		return PH_PREV;
	endfunction

	function automatic flvti_out_t index_entry(input logic [2:0] kind, input logic first);
		flvti_out_t e;
		logic [3:0] fmt;
		e = '0;
		fmt = mflags[7:4];
		e.entry_kind     = kind;
		e.payload_offset = fpos + 32'd1;
		e.payload_size   = left;
		e.time_ms        = ttime;
		e.first_of_track = first;
		if (kind == KIND_VFRAME || kind == KIND_VCONF) begin
			e.key_frame = (fmt == 4'd1);
			e.codec_id  = mflags[3:0];
		end else begin
			e.codec_id = fmt;
			case (mflags[3:2])
				2'd0: e.sample_rate_hz = (fmt == AFMT_NELLY8K) ? 16'd8000 : 16'd5512;
				2'd1: e.sample_rate_hz = 16'd11025;
				2'd2: e.sample_rate_hz = 16'd22050;
				default: e.sample_rate_hz = 16'd44100;
			endcase
			e.channel_count = mflags[0] ? 2'd2 : 2'd1;
			e.sample_bits   = mflags[1] ? 5'd16 : 5'd8;
		end
		return e;
	endfunction

	task automatic video_after_flags();
		if (mflags[3:0] == VCODEC_AVC) begin
			if (left < 24'd4)
				ph = payload_phase();
			else
				ph = PH_VPKT;
		end else begin
			if (left != 24'd0) begin
				index_q.push_back(index_entry(KIND_VFRAME, !vframe_seen));
				vframe_seen = 1'b1;
			end
			ph = payload_phase();
		end
	endtask

	task automatic index_byte(input flvti_in_t w);
		logic [7:0] b;
		flvti_out_t e;
		b = w.data_byte;
		if (w.start_of_file)
			clear_parser();
		case (ph)
			PH_FILEHDR: begin
				if (fpos <= 32'd2) begin
					if ((fpos == 32'd0 && b != SIG_F) || (fpos == 32'd1 && b != SIG_L) ||
							(fpos == 32'd2 && b != SIG_V)) begin
						e = '0;
						e.entry_kind = KIND_BADSIG;
						index_q.push_back(e);
						ph = PH_DEAD;
					end
				end else if (fpos >= 32'd5) begin
					hacc = {hacc[23:0], b};
					if (fpos == 32'd8) begin
						hlen = hacc;
						ph = (hlen > MIN_HDR_LEN) ? PH_HDRSKIP : PH_PREV;
						fbc = '0;
					end
				end
			end
			PH_HDRSKIP: begin
				if (fpos + 32'd1 == hlen) begin
					ph = PH_PREV;
					fbc = '0;
				end
			end
			PH_PREV: begin
				fbc = fbc + 3'd1;
				if (fbc >= 3'd4) begin
					fbc = '0;
					ph = PH_TYPE;
				end
			end
			PH_TYPE: begin
				ttype = b;
				left = '0;
				fbc = '0;
				ph = PH_SIZE;
			end
			PH_SIZE: begin
				left = {left[15:0], b};
				fbc = fbc + 3'd1;
				if (fbc >= 3'd3) begin
					fbc = '0;
					ttime = '0;
					ph = PH_TIME;
				end
			end
			PH_TIME: begin
				ttime = {ttime[15:0], b};
				fbc = fbc + 3'd1;
				if (fbc >= 3'd3) begin
					fbc = '0;
					ph = PH_IGN;
				end
			end
			PH_IGN: begin
				fbc = fbc + 3'd1;
				if (fbc >= 3'd4) begin
					fbc = '0;
					if (left == 24'd0)
						ph = PH_PREV;
					else if (ttype == TAG_AUDIO)
						ph = PH_AFLAGS;
					else if (ttype == TAG_VIDEO)
						ph = PH_VFLAGS;
					else
						ph = PH_SKIP;
				end
			end
			PH_AFLAGS: begin
				mflags = b;
				left = left - 24'd1;
				if (b[7:4] == AFMT_AAC) begin
					ph = (left != 24'd0) ? PH_APKT : PH_PREV;
				end else begin
					if (left != 24'd0) begin
						index_q.push_back(index_entry(KIND_AFRAME, !aframe_seen));
						aframe_seen = 1'b1;
					end
					ph = payload_phase();
				end
			end
			PH_APKT: begin
				left = left - 24'd1;
				if (b == 8'd0) begin
					if (!aconf_seen) begin
						index_q.push_back(index_entry(KIND_ACONF, 1'b0));
						aconf_seen = 1'b1;
					end
				end else if (left != 24'd0) begin
					index_q.push_back(index_entry(KIND_AFRAME, !aframe_seen));
					aframe_seen = 1'b1;
				end
				ph = payload_phase();
			end
			PH_VFLAGS: begin
				mflags = b;
				left = left - 24'd1;
				if (b[3:0] == VCODEC_VP6 || b[3:0] == VCODEC_VP6A)
					ph = (left != 24'd0) ? PH_VEXTRA : PH_PREV;
				else
					video_after_flags();
			end
			PH_VEXTRA: begin
				left = left - 24'd1;
				video_after_flags();
			end
			PH_VPKT: begin
				ttype = b;
				left = left - 24'd1;
				fbc = '0;
				ph = PH_VCTS;
			end
			PH_VCTS: begin
				left = left - 24'd1;
				fbc = fbc + 3'd1;
				if (fbc >= 3'd3) begin
					fbc = '0;
					if (ttype == 8'd0) begin
						if (!vconf_seen) begin
							index_q.push_back(index_entry(KIND_VCONF, 1'b0));
							vconf_seen = 1'b1;
						end
					end else if (left != 24'd0) begin
						index_q.push_back(index_entry(KIND_VFRAME, !vframe_seen));
						vframe_seen = 1'b1;
					end
					ph = payload_phase();
				end
			end
			PH_SKIP: begin
				left = left - 24'd1;
				if (left == 24'd0) begin
					fbc = '0;
					ph = PH_PREV;
				end
			end
			default: begin
			end
		endcase
		fpos = fpos + 32'd1;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic sof);
		flvti_in_t w;
		w.data_byte     = b;
		w.start_of_file = sof;
		file_bytes.push_back(w);
		queued_cnt++;
	endtask

	task automatic add_file();
		int unsigned hl;
		int unsigned ntags;
		int unsigned sz;
		int unsigned nbody;
		int unsigned pick;
		logic [7:0]  tag_b;
		logic [7:0]  flags_b;
		logic [7:0]  pkt_b;
		// pure noise
		if ($urandom_range(11, 0) == 0) begin
			push_byte(8'($urandom), 1'b1);
			repeat ($urandom_range(30, 4))
				push_byte(8'($urandom), 1'b0);
			return;
		end
		push_byte(($urandom_range(19, 0) == 0) ? 8'($urandom) : SIG_F, 1'b1);
		push_byte(($urandom_range(19, 0) == 0) ? 8'($urandom) : SIG_L, 1'b0);
		push_byte(($urandom_range(19, 0) == 0) ? 8'($urandom) : SIG_V, 1'b0);
		push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b0);
		pick = $urandom_range(9, 0);
		if (pick == 0)
			hl = $urandom_range(8, 0);
		else if (pick == 1)
			hl = $urandom_range(24, 10);
		else if (pick == 2)
			hl = $urandom;
		else
			hl = 9;
		for (int i = 3; i >= 0; i--)
			push_byte(8'(hl >> (8 * i)), 1'b0);
		// huge header length, never leaves the skip
		if (hl > 24) begin
			repeat ($urandom_range(20, 1))
				push_byte(8'($urandom), 1'b0);
			return;
		end
		if (hl > 9)
			repeat (hl - 9)
				push_byte(8'($urandom), 1'b0);
		ntags = $urandom_range(6, 1);
		repeat (ntags) begin
			repeat (4)
				push_byte(8'($urandom), 1'b0);
			pick = $urandom_range(9, 0);
			tag_b = (pick < 4) ? TAG_AUDIO : (pick < 8) ? TAG_VIDEO :
				(pick == 8) ? 8'd18 : 8'($urandom);
			push_byte(tag_b, 1'b0);
			pick = $urandom_range(39, 0);
			sz = (pick == 0) ? $urandom_range(24'hFFFFFF, 0) :
				(pick < 5) ? $urandom_range(40, 13) : $urandom_range(12, 0);
			push_byte(8'(sz >> 16), 1'b0);
			push_byte(8'(sz >> 8), 1'b0);
			push_byte(8'(sz), 1'b0);
			repeat (7)
				push_byte(8'($urandom), 1'b0);
			flags_b = 8'($urandom);
			pick = $urandom_range(9, 0);
			if (tag_b == TAG_AUDIO)
				flags_b[7:4] = (pick < 5) ? AFMT_AAC : (pick < 7) ? AFMT_NELLY8K : 4'($urandom);
			else if (tag_b == TAG_VIDEO)
				flags_b[3:0] = (pick < 4) ? VCODEC_AVC : (pick < 6) ? VCODEC_VP6 :
					(pick < 7) ? VCODEC_VP6A : 4'($urandom);
			pick = $urandom_range(3, 0);
			pkt_b = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd1 : 8'($urandom);
			nbody = (sz > 40) ? $urandom_range(30, 0) : sz;
			for (int i = 0; i < nbody; i++)
				push_byte((i == 0) ? flags_b : (i == 1) ? pkt_b : 8'($urandom), 1'b0);
			// cut off by the next file
			if (nbody != sz)
				return;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			mismatches++;
		end
	endtask

	// word driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fired) begin
				if (file_bytes.size() > 0 && $urandom_range(99, 0) >= send_gap_pct) begin
					in_word  <= file_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// accept and compare
	always @(posedge clk) begin
		flvti_out_t e;
		if (arst_n) begin
			in_fired <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				index_byte(in_word);
				accepted_cnt++;
			end
			if (out_valid && out_ready) begin
				if (index_q.size() == 0) begin
					$error("unexpected word, kind %0d offset %0h", out_word.entry_kind,
						out_word.payload_offset);
					mismatches++;
				end else begin
					e = index_q.pop_front();
					check_field("entry_kind", 32'(e.entry_kind), 32'(out_word.entry_kind));
					check_field("payload_offset", e.payload_offset, out_word.payload_offset);
					check_field("payload_size", 32'(e.payload_size),
						32'(out_word.payload_size));
					check_field("time_ms", 32'(e.time_ms), 32'(out_word.time_ms));
					check_field("key_frame", 32'(e.key_frame), 32'(out_word.key_frame));
					check_field("codec_id", 32'(e.codec_id), 32'(out_word.codec_id));
					check_field("sample_rate_hz", 32'(e.sample_rate_hz),
						32'(out_word.sample_rate_hz));
					check_field("channel_count", 32'(e.channel_count),
						32'(out_word.channel_count));
					check_field("sample_bits", 32'(e.sample_bits),
						32'(out_word.sample_bits));
					check_field("first_of_track", 32'(e.first_of_track),
						32'(out_word.first_of_track));
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned target;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		out_ready = 1'b0;
		clear_parser();

		// bad signature at each of the three bytes, the first without a start flag
		push_byte(8'h58, 1'b0);
		push_byte(SIG_L, 1'b0);
		push_byte(SIG_F, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(SIG_F, 1'b1);
		push_byte(SIG_L, 1'b0);
		push_byte(8'hFF, 1'b0);
		// short header length, aac config with empty payload, extreme time
		push_byte(SIG_F, 1'b1);
		push_byte(SIG_L, 1'b0);
		push_byte(SIG_V, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h05, 1'b0);
		repeat (4)
			push_byte(8'h00, 1'b0);
		repeat (4)
			push_byte(8'hFF, 1'b0);
		push_byte(TAG_AUDIO, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h02, 1'b0);
		repeat (3)
			push_byte(8'hFF, 1'b0);
		repeat (4)
			push_byte(8'h00, 1'b0);
		push_byte(8'hAF, 1'b0);
		push_byte(8'h00, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 3; p++) begin
			target = queued_cnt + 617;
			while (queued_cnt < target)
				add_file();
			@(negedge clk);
			while (accepted_cnt != queued_cnt)
				@(negedge clk);
			@(posedge clk);
			if (p == 0) begin
				send_gap_pct   = 69;
				recv_stall_pct = 16;
			end else begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
		end

		@(negedge clk);
		while (index_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (index_q.size() != 0) begin
			$error("%0d expected words never arrived", index_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
